### rtl/core/uwts_pkg.sv
// Shared types, constants and the whitespace classifier for the UTF-8
// whitespace trim scanner. No dependencies.
package uwts_pkg;

    localparam logic [15:0] MAX_BYTES = 16'd65535;

    localparam logic [7:0] LEAD2_MASK  = 8'hE0;
    localparam logic [7:0] LEAD2_CODE  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK  = 8'hF0;
    localparam logic [7:0] LEAD3_CODE  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK  = 8'hF8;
    localparam logic [7:0] LEAD4_CODE  = 8'hF0;
    localparam logic [7:0] CONT_MASK   = 8'hC0;
    localparam logic [7:0] CONT_CODE   = 8'h80;

    typedef logic [20:0] cp_t;
    typedef logic [2:0][7:0] pend_t;

    typedef struct packed {
        logic [15:0] byte_count;
        logic [1:0]  pend_cnt;
        logic [2:0]  seq_w;
        cp_t         cp;
        logic        found;
        logic [15:0] first_off;
        logic [15:0] last_end;
        logic        overflowed;
    } scan_state_t;

    typedef struct packed {
        logic [15:0] span_start;
        logic [15:0] span_length;
        logic        all_blank;
        logic        too_long;
    } span_t;

    function automatic logic is_blank(input cp_t cp);
        return (cp >= 21'h09 && cp <= 21'h0D) || (cp >= 21'h1C && cp <= 21'h20) ||
               cp == 21'h85 || cp == 21'hA0 || cp == 21'h1680 ||
               (cp >= 21'h2000 && cp <= 21'h200A) || cp == 21'h2028 ||
               cp == 21'h2029 || cp == 21'h202F || cp == 21'h205F ||
               cp == 21'h3000;
    endfunction

endpackage

### rtl/core/utf8_whitespace_trim_scanner.sv
// Top level of the UTF-8 whitespace trim scanner: input register, scanner
// state, pending byte store and result register. Depends on uwts_pkg and
// uwts_scan_step.
//
// Usage:
//   Input channel (text_valid/text_ready) carries one string byte per
//   transaction in text_byte; is_final marks the last byte of a string.
//   Output channel (span_valid/span_ready) carries one transaction per
//   string: span_start, span_length, all_blank, too_long.
//   One byte per cycle sustained. A byte is registered at acceptance and
//   resolved in the following cycle unless it is a final byte that waits;
//   the result of a final byte is registered when that byte is resolved.
//   Scanner state clears after each final byte, so strings follow each
//   other with no gap. Throughput is set by the combinational state update
//   in uwts_scan_step. When span_ready is low with a result held, non-final
//   bytes still advance; a final byte waits in the input register, and
//   text_ready drops only while it waits.
//   Reset clears all control state and scanner counters; no clearing
//   pass is needed and bytes are taken right after reset.
module utf8_whitespace_trim_scanner (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        text_valid,
    output logic        text_ready,
    input  logic [7:0]  text_byte,
    input  logic        is_final,
    output logic        span_valid,
    input  logic        span_ready,
    output logic [15:0] span_start,
    output logic [15:0] span_length,
    output logic        all_blank,
    output logic        too_long
);

    logic                  in_valid_reg;
    logic [7:0]            byte_reg;
    logic                  final_reg;
    uwts_pkg::scan_state_t state_reg;
    uwts_pkg::scan_state_t state_next;
    uwts_pkg::pend_t       pend_reg;
    logic                  out_valid_reg;
    uwts_pkg::span_t       span_reg;
    uwts_pkg::span_t       span_next;
    logic                  pend_we;
    logic [1:0]            pend_idx;
    logic                  step_go;
    logic                  take;

    assign step_go    = in_valid_reg && !(final_reg && out_valid_reg && !span_ready);
    assign text_ready = !in_valid_reg || step_go;
    assign take       = text_valid && text_ready;

    uwts_scan_step u_step (
        .cur       (state_reg),
        .pend      (pend_reg),
        .text_byte (byte_reg),
        .is_final  (final_reg),
        .nxt       (state_next),
        .pend_we   (pend_we),
        .pend_idx  (pend_idx),
        .span      (span_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (step_go)
            begin
                in_valid_reg <= 1'b0;
            end
            if (step_go)
            begin
                state_reg <= state_next;
            end
            if (step_go && final_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (span_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg  <= text_byte;
            final_reg <= is_final;
        end
        if (step_go && pend_we)
        begin
            pend_reg[pend_idx] <= byte_reg;
        end
        if (step_go && final_reg)
        begin
            span_reg <= span_next;
        end
    end

    assign span_valid  = out_valid_reg;
    assign span_start  = span_reg.span_start;
    assign span_length = span_reg.span_length;
    assign all_blank   = span_reg.all_blank;
    assign too_long    = span_reg.too_long;

endmodule

### rtl/core/uwts_scan_step.sv
// One byte of decode and trim bookkeeping: next scanner state and span.
// Depends on uwts_pkg.
module uwts_scan_step (
    input  uwts_pkg::scan_state_t cur,
    input  uwts_pkg::pend_t       pend,
    input  logic [7:0]            text_byte,
    input  logic                  is_final,
    output uwts_pkg::scan_state_t nxt,
    output logic                  pend_we,
    output logic [1:0]            pend_idx,
    output uwts_pkg::span_t       span
);

    logic        sat;
    logic [15:0] pos;
    logic        is_cont;
    logic        open_seq;
    logic        extend;
    logic        complete;
    logic [2:0]  lead_w;
    uwts_pkg::cp_t lead_bits;
    uwts_pkg::cp_t new_cp;
    logic        flush_old;
    logic [4:0]  act;
    logic [4:0]  blank;
    logic [4:0]  nb;
    logic [15:0] off [5];
    logic [15:0] fin [5];
    logic [15:0] first_cand;
    logic [15:0] last_cand;
    logic        found_n;
    logic [15:0] first_n;
    logic [15:0] last_n;
    logic        ovf_n;

    assign sat      = (cur.byte_count == uwts_pkg::MAX_BYTES);
    assign pos      = sat ? uwts_pkg::MAX_BYTES : cur.byte_count;
    assign is_cont  = ((text_byte & uwts_pkg::CONT_MASK) == uwts_pkg::CONT_CODE);
    assign open_seq = (cur.pend_cnt != 2'd0);
    assign extend   = open_seq && is_cont;
    assign complete = (({1'b0, cur.pend_cnt} + 3'd1) >= cur.seq_w);
    assign new_cp   = {cur.cp[14:0], text_byte[5:0]};

    always_comb
    begin
        lead_w    = 3'd0;
        lead_bits = '0;
        priority if ((text_byte & uwts_pkg::LEAD2_MASK) == uwts_pkg::LEAD2_CODE)
        begin
            lead_w    = 3'd2;
            lead_bits = {16'd0, text_byte[4:0]};
        end
        else if ((text_byte & uwts_pkg::LEAD3_MASK) == uwts_pkg::LEAD3_CODE)
        begin
            lead_w    = 3'd3;
            lead_bits = {17'd0, text_byte[3:0]};
        end
        else if ((text_byte & uwts_pkg::LEAD4_MASK) == uwts_pkg::LEAD4_CODE)
        begin
            lead_w    = 3'd4;
            lead_bits = {18'd0, text_byte[2:0]};
        end
        else
        begin
            lead_w    = 3'd0;
            lead_bits = '0;
        end
    end

    // Slots in byte order: three flushed pending bytes, the byte itself,
    // then a completed multibyte character.
    assign flush_old = open_seq && (!is_cont || (is_final && !complete));

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            act[i]   = flush_old && (i < int'(cur.pend_cnt));
            blank[i] = uwts_pkg::is_blank({13'd0, pend[i]});
            off[i]   = pos - {14'd0, cur.pend_cnt} + 16'(i);
            fin[i]   = off[i] + 16'd1;
        end
        act[3]   = is_final ? !(extend && complete)
                            : (!extend && (lead_w == 3'd0));
        blank[3] = uwts_pkg::is_blank({13'd0, text_byte});
        off[3]   = pos;
        fin[3]   = pos + 16'd1;
        act[4]   = extend && complete;
        blank[4] = uwts_pkg::is_blank(new_cp);
        off[4]   = pos + 16'd1 - {13'd0, cur.seq_w};
        fin[4]   = pos + 16'd1;
        nb       = act & ~blank;
    end

    always_comb
    begin
        first_cand = '0;
        last_cand  = '0;
        for (int i = 4; i >= 0; i--)
        begin
            if (nb[i])
            begin
                first_cand = off[i];
            end
        end
        for (int i = 0; i < 5; i++)
        begin
            if (nb[i])
            begin
                last_cand = fin[i];
            end
        end
    end

    assign found_n = cur.found || (nb != 5'd0);
    assign first_n = cur.found ? cur.first_off : first_cand;
    assign last_n  = (nb != 5'd0) ? last_cand : cur.last_end;
    assign ovf_n   = cur.overflowed || sat;

    always_comb
    begin
        pend_we  = 1'b0;
        pend_idx = '0;
        nxt      = '0;
        if (!is_final)
        begin
            nxt.byte_count = sat ? cur.byte_count : cur.byte_count + 16'd1;
            nxt.found      = found_n;
            nxt.first_off  = first_n;
            nxt.last_end   = last_n;
            nxt.overflowed = ovf_n;
            if (extend)
            begin
                pend_we  = (cur.pend_cnt != 2'd3);
                pend_idx = cur.pend_cnt;
                if (!complete)
                begin
                    nxt.pend_cnt = cur.pend_cnt + 2'd1;
                    nxt.seq_w    = cur.seq_w;
                    nxt.cp       = new_cp;
                end
            end
            else if (lead_w != 3'd0)
            begin
                pend_we      = 1'b1;
                pend_idx     = 2'd0;
                nxt.pend_cnt = 2'd1;
                nxt.seq_w    = lead_w;
                nxt.cp       = lead_bits;
            end
        end
    end

    assign span.span_start  = found_n ? first_n : 16'd0;
    assign span.span_length = found_n ? (last_n - first_n) : 16'd0;
    assign span.all_blank   = !found_n;
    assign span.too_long    = ovf_n;

endmodule

### verif/utf8_whitespace_trim_scanner_tb.sv
// Self-checking testbench for utf8_whitespace_trim_scanner: random and directed
// UTF-8 strings, an in-bench span predictor and a result scoreboard.
// Depends on uwts_pkg and the scanner RTL.
`timescale 1ns / 1ps

module utf8_whitespace_trim_scanner_tb;

    class span_scoreboard;
        int unsigned byte_pos;
        int unsigned first_off;
        int unsigned last_end;
        logic [7:0]  pend [3];
        int unsigned pend_cnt;
        int unsigned seq_w;
        logic [20:0] part_cp;
        bit          found;
        bit          ovf;
        uwts_pkg::span_t exp_q[$];
        int unsigned n_err;
        int unsigned n_strings;
        int unsigned n_bytes;
        int unsigned n_blank;
        int unsigned n_long;

        function new();
            clear_scan();
        endfunction

        function void clear_scan();
            byte_pos  = 0;
            first_off = 0;
            last_end  = 0;
            pend_cnt  = 0;
            seq_w     = 0;
            part_cp   = '0;
            found     = 1'b0;
            ovf       = 1'b0;
        endfunction

        function bit space_cp(int unsigned cp);
            return cp inside {['h09:'h0D], ['h1C:'h20], 'h85, 'hA0, 'h1680,
                              ['h2000:'h200A], 'h2028, 'h2029, 'h202F, 'h205F,
                              'h3000};
        endfunction

        function void mark_char(int unsigned cp, int unsigned off, int unsigned w);
            if (!space_cp(cp))
            begin
                if (!found)
                begin
                    first_off = off;
                    found     = 1'b1;
                end
                last_end = off + w;
            end
        endfunction

        function void split_pending(int unsigned base);
            for (int unsigned i = 0; i < pend_cnt && i < 3; i++)
                mark_char(32'(pend[i]), base + i, 1);
            pend_cnt = 0;
            seq_w    = 0;
            part_cp  = '0;
        endfunction

        function void begin_char(logic [7:0] b, int unsigned pos);
            int unsigned w;
            logic [20:0] bits;
            w    = 0;
            bits = '0;
            if ((b & uwts_pkg::LEAD2_MASK) == uwts_pkg::LEAD2_CODE)
            begin
                w    = 2;
                bits = 21'(b[4:0]);
            end
            else if ((b & uwts_pkg::LEAD3_MASK) == uwts_pkg::LEAD3_CODE)
            begin
                w    = 3;
                bits = 21'(b[3:0]);
            end
            else if ((b & uwts_pkg::LEAD4_MASK) == uwts_pkg::LEAD4_CODE)
            begin
                w    = 4;
                bits = 21'(b[2:0]);
            end
            if (w == 0)
            begin
                mark_char(32'(b), pos, 1);
                return;
            end
            pend[0]  = b;
            pend_cnt = 1;
            seq_w    = w;
            part_cp  = bits;
        endfunction

        // Called once per accepted input transaction.
        function void note_byte(logic [7:0] b, logic fin);
            int unsigned pos;
            uwts_pkg::span_t s;
            n_bytes++;
            if (byte_pos >= 32'(uwts_pkg::MAX_BYTES))
            begin
                ovf = 1'b1;
                pos = 32'(uwts_pkg::MAX_BYTES);
            end
            else
            begin
                pos = byte_pos;
                byte_pos++;
            end

            if (pend_cnt == 0)
                begin_char(b, pos);
            else if ((b & uwts_pkg::CONT_MASK) == uwts_pkg::CONT_CODE)
            begin
                part_cp = {part_cp[14:0], b[5:0]};
                if (pend_cnt < 3)
                    pend[pend_cnt] = b;
                pend_cnt++;
                if (pend_cnt >= seq_w)
                begin
                    mark_char(32'(part_cp), pos + 1 - seq_w, seq_w);
                    pend_cnt = 0;
                    seq_w    = 0;
                    part_cp  = '0;
                end
            end
            else
            begin
                split_pending(pos - pend_cnt);
                begin_char(b, pos);
            end

            if (!fin)
                return;
            if (pend_cnt != 0)
                split_pending(pos + 1 - pend_cnt);

            s.span_start  = found ? 16'(first_off) : 16'd0;
            s.span_length = found ? 16'(last_end - first_off) : 16'd0;
            s.all_blank   = !found;
            s.too_long    = ovf;
            exp_q = {exp_q, s};
            n_strings++;
            if (!found)
                n_blank++;
            if (ovf)
                n_long++;
            clear_scan();
        endfunction

        function void check_span(uwts_pkg::span_t got);
            uwts_pkg::span_t want;
            if (exp_q.size() == 0)
            begin
                $error("span result with no string pending");
                n_err++;
                return;
            end
            want = exp_q.pop_front();
            if (got.span_start !== want.span_start)
            begin
                $error("span_start: expected %0d, got %0d", want.span_start, got.span_start);
                n_err++;
            end
            if (got.span_length !== want.span_length)
            begin
                $error("span_length: expected %0d, got %0d",
                       want.span_length, got.span_length);
                n_err++;
            end
            if (got.all_blank !== want.all_blank)
            begin
                $error("all_blank: expected %0d, got %0d", want.all_blank, got.all_blank);
                n_err++;
            end
            if (got.too_long !== want.too_long)
            begin
                $error("too_long: expected %0d, got %0d", want.too_long, got.too_long);
                n_err++;
            end
        endfunction
    endclass

    localparam int unsigned NEAR_CP [20] = '{'h08, 'h0E, 'h1B, 'h21, 'h84, 'h86, 'h9F,
                                             'hA1, 'h167F, 'h1681, 'h1FFF, 'h200B,
                                             'h2027, 'h202A, 'h202E, 'h2030, 'h205E,
                                             'h2060, 'h2FFF, 'h3001};
    localparam int unsigned WIDE_SP [8] = '{'h85, 'hA0, 'h1680, 'h2028, 'h2029,
                                            'h202F, 'h205F, 'h3000};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        text_valid = 1'b0;
    logic        text_ready;
    logic [7:0]  text_byte = 8'h00;
    logic        is_final = 1'b0;
    logic        span_valid;
    logic        span_ready = 1'b0;
    logic [15:0] span_start;
    logic [15:0] span_length;
    logic        all_blank;
    logic        too_long;

    int unsigned    send_idle_pct = 0;
    int unsigned    stall_pct = 0;
    logic [7:0]     str_q[$];
    span_scoreboard sb = new();

    utf8_whitespace_trim_scanner u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_valid  (text_valid),
        .text_ready  (text_ready),
        .text_byte   (text_byte),
        .is_final    (is_final),
        .span_valid  (span_valid),
        .span_ready  (span_ready),
        .span_start  (span_start),
        .span_length (span_length),
        .all_blank   (all_blank),
        .too_long    (too_long)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
        span_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && span_valid && span_ready)
            sb.check_span(uwts_pkg::span_t'{span_start, span_length, all_blank, too_long});
    end

    initial
    begin
        #20_000_000;
        $display("utf8_whitespace_trim_scanner_tb: FAIL");
        $finish;
    end

    function automatic void append_byte(input logic [7:0] b);
        str_q = {str_q, b};
    endfunction

    function automatic int unsigned pick_blank();
        case ($urandom_range(5))
            0: return 'h09 + $urandom_range(4);
            1: return 'h1C + $urandom_range(4);
            2: return 'h2000 + $urandom_range(10);
            3: return WIDE_SP[$urandom_range(7)];
            default: return 'h20;
        endcase
    endfunction

    function automatic int unsigned pick_text();
        case ($urandom_range(5))
            0: return NEAR_CP[$urandom_range(19)];
            1: return $urandom_range('h80, 'h7FF);
            2: return $urandom_range('h800, 'hFFFF);
            3: return $urandom_range('h10000, 'h1FFFFF);
            default: return $urandom_range('h21, 'h7E);
        endcase
    endfunction

    // Occasionally overlong: same code point, one byte wider.
    function automatic void add_char(int unsigned cp);
        int unsigned w;
        w = (cp < 'h80) ? 1 : (cp < 'h800) ? 2 : (cp < 'h10000) ? 3 : 4;
        if (w < 4 && $urandom_range(15) == 0)
            w++;
        case (w)
            1: append_byte(cp[7:0]);
            2:
            begin
                append_byte({3'b110, cp[10:6]});
                append_byte({2'b10, cp[5:0]});
            end
            3:
            begin
                append_byte({4'b1110, cp[15:12]});
                append_byte({2'b10, cp[11:6]});
                append_byte({2'b10, cp[5:0]});
            end
            default:
            begin
                append_byte({5'b11110, cp[20:18]});
                append_byte({2'b10, cp[17:12]});
                append_byte({2'b10, cp[11:6]});
                append_byte({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    function automatic void add_noise();
        int unsigned w;
        case ($urandom_range(5))
            0: append_byte(8'($urandom_range(255)));
            1: append_byte({2'b10, 6'($urandom_range(63))});
            2: append_byte(8'($urandom_range(8'hF8, 8'hFF)));
            3:
            begin
                w = $urandom_range(2, 4);
                case (w)
                    2: append_byte({3'b110, 5'($urandom_range(31))});
                    3: append_byte({4'b1110, 4'($urandom_range(15))});
                    default: append_byte({5'b11110, 3'($urandom_range(7))});
                endcase
                repeat ($urandom_range(w - 2))
                    append_byte({2'b10, 6'($urandom_range(63))});
            end
            4:
            begin
                append_byte({4'b1110, 4'($urandom_range(15))});
                append_byte($urandom_range(1) ? 8'h85 : 8'hA0);
            end
            default:
            begin
                append_byte({5'b11110, 3'($urandom_range(7))});
                append_byte($urandom_range(1) ? 8'h85 : 8'hA0);
                append_byte($urandom_range(1) ? 8'h85 : 8'hA0);
            end
        endcase
    endfunction

    function automatic void build_string();
        int unsigned n_body;
        str_q.delete();
        n_body = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
        repeat ($urandom_range(3))
            add_char(pick_blank());
        repeat (n_body)
        begin
            if ($urandom_range(11) == 0)
                add_noise();
            else if ($urandom_range(3) == 0)
                add_char(pick_blank());
            else
                add_char(pick_text());
        end
        repeat ($urandom_range(3))
            add_char(pick_blank());
        if ($urandom_range(7) == 0)
            add_noise();
        if (str_q.size() == 0)
            add_char(pick_blank());
    endfunction

    // Entered and left just after a rising edge.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            text_valid <= 1'b0;
            @(posedge clk);
        end
        text_valid <= 1'b1;
        text_byte  <= b;
        is_final   <= fin;
        do
            @(posedge clk);
        while (!text_ready);
        sb.note_byte(b, fin);
    endtask

    task automatic send_string();
        foreach (str_q[i])
            send_byte(str_q[i], i == str_q.size() - 1);
    endtask

    task automatic drain();
        text_valid <= 1'b0;
        @(posedge clk);
        while (sb.exp_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_random(input int unsigned target);
        int unsigned sent;
        sent = 0;
        while (sent < target)
        begin
            build_string();
            sent += str_q.size();
            send_string();
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        str_q = '{8'h00};                                            send_string();
        str_q = '{8'hFF};                                            send_string();
        str_q = '{8'h20};                                            send_string();
        str_q = '{8'h0D, 8'h7E, 8'h1C};                              send_string();
        str_q = '{8'hE3, 8'h80, 8'h80, 8'h41, 8'hE2, 8'h80, 8'hAF};  send_string();
        str_q = '{8'hC3, 8'h41};                                     send_string();
        str_q = '{8'h20, 8'hE1, 8'h85, 8'h20};                       send_string();
        str_q = '{8'h41, 8'hF0, 8'hA0, 8'h85};                       send_string();
        str_q = '{8'h80, 8'hF8, 8'hC2, 8'h85};                       send_string();
        drain();

        run_random(490);
        drain();
        send_idle_pct = 77;
        run_random(490);
        drain();
        send_idle_pct = 0;
        stall_pct     = 77;
        run_random(490);
        drain();
        send_idle_pct = 16;
        stall_pct     = 16;
        run_random(490);
        drain();
        repeat (8) @(posedge clk);

        $display("Covered %0d strings, %0d bytes: %0d all blank, %0d over the length limit.",
                 sb.n_strings, sb.n_bytes, sb.n_blank, sb.n_long);
        if (sb.n_err == 0)
            $display("utf8_whitespace_trim_scanner_tb: PASS");
        else
            $display("utf8_whitespace_trim_scanner_tb: FAIL");
        $finish;
    end

endmodule

### filelist.f
rtl/core/uwts_pkg.sv
rtl/core/uwts_scan_step.sv
rtl/core/utf8_whitespace_trim_scanner.sv
verif/utf8_whitespace_trim_scanner_tb.sv
